// ----- hw/rtl/psx_pkg.sv -----
// Shared types, constants and helper functions of the plane stress transform.
package psx_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SII = 2'd0;
  localparam logic [1:0] REG_SJJ = 2'd1;
  localparam logic [1:0] REG_SIJ = 2'd2;

  // Rotation start value, about 2^29 divided by the CORDIC gain.
  localparam logic signed [31:0] INV_GAIN_Q29 = 32'sd326016437;
  // Upper and lower halves of 2^32 divided by the CORDIC gain.
  localparam logic [15:0] GAIN_HI = 16'd39796;
  localparam logic [15:0] GAIN_LO = 16'd60840;
  // Half a turn in 2^32 units per turn.
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

  // Data that moves from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [33:0] rz;
    logic               flip;
    logic signed [35:0] vx;
    logic signed [35:0] vy;
    logic signed [33:0] vz;
  } psx_cordic_t;

  // Arctangent of 2^-i in 2^32 units per turn.
  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/plane_stress_transform.sv -----
// Top level of the plane stress transform: configuration, CORDIC cell chain and post stages.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    rotation_angle
//   out_     output     out_valid / out_ready  rotated stresses, circle, principal values
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One item is taken per cycle while no output stall holds the chain; each item passes from
// acceptance to result through the chain of CORDIC cells and three post stages.
// Synchronous active-low reset clears all valid flags and the stress registers.
// A stall at the output fills empty stages first, then stops the chain.
module plane_stress_transform import psx_pkg::*; #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [15:0] in_rotation_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rotated_s11,
  output logic signed [31:0] out_rotated_s22,
  output logic signed [31:0] out_rotated_s12,
  output logic signed [31:0] out_circle_center,
  output logic        [30:0] out_circle_radius,
  output logic signed [31:0] out_principal_max,
  output logic signed [31:0] out_principal_min,
  output logic        [14:0] out_principal_direction,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_wdata
);

  logic signed [31:0] sii_r, sjj_r, sij_r;
  logic signed [32:0] sum, diff, sij2;

  psx_cordic_t stg_data  [CORDIC_STAGES+1];
  logic        stg_valid [CORDIC_STAGES+1];
  logic        stg_ready [CORDIC_STAGES+1];

  psx_cordic_t cordic_in;

  logic [31:0] phi;
  logic        flip;

  // Stress registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sii_r <= '0;
      sjj_r <= '0;
      sij_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SII: sii_r <= cfg_wdata;
        REG_SJJ: sjj_r <= cfg_wdata;
        REG_SIJ: sij_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sum  = 33'(sii_r) + 33'(sjj_r);
  assign diff = 33'(sii_r) - 33'(sjj_r);
  assign sij2 = 33'(sij_r) <<< 1;

  // Twice the angle, reduced to a half turn around zero.
  assign phi  = {in_rotation_angle[14:0], 17'b0};
  assign flip = (phi[31:30] == 2'b01) || (phi[31:30] == 2'b10);

  always_comb begin
    cordic_in.rx   = INV_GAIN_Q29;
    cordic_in.ry   = '0;
    cordic_in.rz   = 34'($signed({phi[31] ^ flip, phi[30:0]}));
    cordic_in.flip = flip;
    if (diff < 0) begin
      cordic_in.vx = -36'(diff);
      cordic_in.vy = -36'(sij2);
      cordic_in.vz = HALF_TURN;
    end else begin
      cordic_in.vx = 36'(diff);
      cordic_in.vy = 36'(sij2);
      cordic_in.vz = '0;
    end
  end

  assign stg_data[0]  = cordic_in;
  assign stg_valid[0] = in_valid;
  assign in_ready     = stg_ready[0];

  // Chain of CORDIC cells.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    psx_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  psx_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (stg_valid[CORDIC_STAGES]),
    .up_ready   (stg_ready[CORDIC_STAGES]),
    .up_data    (stg_data[CORDIC_STAGES]),
    .sum        (sum),
    .diff       (diff),
    .sij        (sij_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_s11    (out_rotated_s11),
    .out_s22    (out_rotated_s22),
    .out_s12    (out_rotated_s12),
    .out_center (out_circle_center),
    .out_radius (out_circle_radius),
    .out_pmax   (out_principal_max),
    .out_pmin   (out_principal_min),
    .out_dir    (out_principal_direction)
  );

  // The maximum principal stress is no lower than the minimum or the circle center.
  a_pmax_ge_pmin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_principal_max >= out_principal_min))
    else $error("principal_max below principal_min");

  a_pmax_ge_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_principal_max >= out_circle_center))
    else $error("principal_max below circle center");

  // A degenerate circle has no principal direction.
  a_zero_radius_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_circle_radius == 31'd0)) |-> (out_principal_direction == 15'd0))
    else $error("direction set for zero radius");

  // A waiting result is never dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ----- hw/rtl/psx_cell.sv -----
// One CORDIC cell: a rotation step and a vectoring step with a pipeline register.
module psx_cell import psx_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  psx_cordic_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output psx_cordic_t dn_data
);

  localparam logic signed [33:0] ATAN = atan_turn(STAGE);

  logic        valid_r;
  psx_cordic_t data_r;
  psx_cordic_t data_nxt;
  logic        adv;

  logic signed [31:0] rx, ry;
  logic signed [35:0] vx, vy;

  // The register may load when it is empty or its content moves on.
  assign adv      = !valid_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Rotation toward the residual angle and vectoring toward the x axis.
  always_comb begin
    rx = up_data.rx;
    ry = up_data.ry;
    vx = up_data.vx;
    vy = up_data.vy;
    data_nxt = up_data;
    if (up_data.rz >= 0) begin
      data_nxt.rx = rx - (ry >>> STAGE);
      data_nxt.ry = ry + (rx >>> STAGE);
      data_nxt.rz = up_data.rz - ATAN;
    end else begin
      data_nxt.rx = rx + (ry >>> STAGE);
      data_nxt.ry = ry - (rx >>> STAGE);
      data_nxt.rz = up_data.rz + ATAN;
    end
    if (vy > 0) begin
      data_nxt.vx = vx + (vy >>> STAGE);
      data_nxt.vy = vy - (vx >>> STAGE);
      data_nxt.vz = up_data.vz + ATAN;
    end else begin
      data_nxt.vx = vx - (vy >>> STAGE);
      data_nxt.vy = vy + (vx >>> STAGE);
      data_nxt.vz = up_data.vz - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hw/rtl/psx_post.sv -----
// Post processing: products, rounding, radius scaling, saturation and output register.
module psx_post import psx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  psx_cordic_t        up_data,
  input  logic signed [32:0] sum,
  input  logic signed [32:0] diff,
  input  logic signed [31:0] sij,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_s11,
  output logic signed [31:0] out_s22,
  output logic signed [31:0] out_s12,
  output logic signed [31:0] out_center,
  output logic        [30:0] out_radius,
  output logic signed [31:0] out_pmax,
  output logic signed [31:0] out_pmin,
  output logic        [14:0] out_dir
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  // First stage: products.
  logic signed [64:0] p1_r, p3_r;
  logic signed [63:0] p2_r, p4_r;
  logic        [50:0] mh_r, ml_r;
  logic               flip1_r;
  logic        [31:0] theta1_r;
  logic        [34:0] mag;

  // Second stage: rounded sums and radius.
  logic signed [37:0] s11_r, s12_r;
  logic        [35:0] r_r;
  logic        [31:0] theta2_r;
  logic signed [67:0] prod11, prod12, n11, n12;
  logic        [51:0] t_sum;
  logic        [52:0] t_rnd;
  logic        [35:0] r_nxt;

  // Third stage: saturated outputs.
  logic signed [31:0] center;
  logic signed [39:0] s22_w, pmax_w, pmin_w;
  logic        [32:0] dir_w;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign out_valid = v3_r;

  assign mag = up_data.vx[34:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stress products with sine and cosine, and the magnitude times the inverse gain.
  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      p1_r     <= diff * up_data.rx;
      p2_r     <= sij * up_data.ry;
      p3_r     <= diff * up_data.ry;
      p4_r     <= sij * up_data.rx;
      mh_r     <= mag * GAIN_HI;
      ml_r     <= mag * GAIN_LO;
      flip1_r  <= up_data.flip;
      theta1_r <= up_data.vz[31:0];
    end
  end

  // The half-turn reduction negates the products of sine and cosine.
  always_comb begin
    prod11 = 68'(p1_r) + (68'(p2_r) <<< 1);
    prod12 = (68'(p4_r) <<< 1) - 68'(p3_r);
    n11    = (68'(sum) <<< 29) + (flip1_r ? -prod11 : prod11) + (68'sd1 <<< 29);
    n12    = (flip1_r ? -prod12 : prod12) + (68'sd1 <<< 29);
    t_sum  = 52'(mh_r) + 52'(ml_r[50:16]);
    t_rnd  = 53'(t_sum) + 53'd65536;
    r_nxt  = t_rnd[52:17];
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      s11_r    <= n11[67:30];
      s12_r    <= n12[67:30];
      r_r      <= r_nxt;
      theta2_r <= theta1_r;
    end
  end

  // Principal stresses, direction and saturation.
  always_comb begin
    center = sum[32:1];
    s22_w  = 40'(sum) - 40'(s11_r);
    pmax_w = 40'(center) + $signed({4'b0, r_r});
    pmin_w = 40'(center) - $signed({4'b0, r_r});
    dir_w  = 33'(theta2_r) + 33'd65536;
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      out_s11    <= sat32(40'(s11_r));
      out_s22    <= sat32(s22_w);
      out_s12    <= sat32(40'(s12_r));
      out_center <= center;
      out_radius <= (r_r > 36'd2147483647) ? 31'h7FFFFFFF : r_r[30:0];
      out_pmax   <= sat32(pmax_w);
      out_pmin   <= sat32(pmin_w);
      out_dir    <= (r_r == 36'd0) ? 15'd0 : dir_w[31:17];
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the plane stress transform.
`timescale 1ns / 100ps

module testbench;
  import psx_pkg::*;

  localparam int NUM_STAGES = 20;
  localparam int HALF_PERIOD = 6;
  localparam int SETTLE_CYCLES = NUM_STAGES + 12;

  // One result item of the block.
  typedef struct {
    longint s11;
    longint s22;
    longint s12;
    longint center;
    longint radius;
    longint pmax;
    longint pmin;
    longint direction;
  } stress_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_rotation_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_rotated_s11;
  logic signed [31:0] out_rotated_s22;
  logic signed [31:0] out_rotated_s12;
  logic signed [31:0] out_circle_center;
  logic [30:0] out_circle_radius;
  logic signed [31:0] out_principal_max;
  logic signed [31:0] out_principal_min;
  logic [14:0] out_principal_direction;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Stress state as the testbench believes the block holds it.
  logic signed [31:0] stress_sii = '0;
  logic signed [31:0] stress_sjj = '0;
  logic signed [31:0] stress_sij = '0;

  stress_result_t pending_results[$];
  int error_count = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit rx_hold = 1'b0;
  int rx_wait = 0;

  // Arctangent of 2^-i in 2^32 units per turn.
  longint atan_steps[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  plane_stress_transform #(.CORDIC_STAGES(NUM_STAGES)) i_dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #20ms;
    $display("plane_stress_transform verification failed");
    $finish;
  end

  function automatic longint clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotated stresses and Mohr circle for one rotation angle.
  function automatic stress_result_t predict_stresses(input logic [15:0] angle);
    stress_result_t res;
    longint sii, sjj, sij, sum, d, x, y, z, nx, n11, n12, s11, center, rr;
    logic [31:0] phi;
    logic [1:0] quadrant;
    bit flip;
    longint unsigned m, t, r, theta;
    sii = longint'(stress_sii);
    sjj = longint'(stress_sjj);
    sij = longint'(stress_sij);
    sum = sii + sjj;
    d = sii - sjj;

    // Sine and cosine of twice the angle, reduced to the right half plane.
    phi = {angle[14:0], 17'b0};
    quadrant = phi[31:30];
    flip = (quadrant == 2'd1) || (quadrant == 2'd2);
    if (flip) phi = phi - 32'h8000_0000;
    z = longint'($signed(phi));
    x = longint'(INV_GAIN_Q29);
    y = 0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_steps[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_steps[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    n11 = sum * 64'sd536870912 + d * x + 2 * sij * y;
    n12 = -(d * y) + 2 * sij * x;
    s11 = (n11 + 64'sd536870912) >>> 30;
    res.s11 = clamp_q16(s11);
    res.s22 = clamp_q16(sum - s11);
    res.s12 = clamp_q16((n12 + 64'sd536870912) >>> 30);
    center = sum >>> 1;
    res.center = clamp_q16(center);

    // Vectoring of (d, 2*sij) gives the radius and the principal direction.
    x = d;
    y = 2 * sij;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd2147483648;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_steps[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_steps[i];
      end
      x = nx;
    end
    m = x;
    t = m * 64'd39796 + ((m * 64'd60840) >> 16);
    r = (t + 64'd65536) >> 17;
    rr = longint'(r);
    res.radius = (r > 64'd2147483647) ? 64'd2147483647 : r;
    res.pmax = clamp_q16(center + rr);
    res.pmin = clamp_q16(center - rr);
    theta = {32'b0, z[31:0]};
    res.direction = (r == 0) ? 0 : longint'(((theta + 64'd65536) >> 17) & 64'h7FFF);
    return res;
  endfunction

  // Receiver: ready, with random stalls when enabled, plus a long hold when asked.
  always @(posedge clk) begin
    int w;
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (out_ready && out_valid) begin
      w = rx_idle_en ? $urandom_range(0, 13) : 0;
      if (w == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_wait <= w - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin
    stress_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        compare_field("rotated_s11", e.s11, longint'(out_rotated_s11));
        compare_field("rotated_s22", e.s22, longint'(out_rotated_s22));
        compare_field("rotated_s12", e.s12, longint'(out_rotated_s12));
        compare_field("circle_center", e.center, longint'(out_circle_center));
        compare_field("circle_radius", e.radius, longint'({1'b0, out_circle_radius}));
        compare_field("principal_max", e.pmax, longint'(out_principal_max));
        compare_field("principal_min", e.pmin, longint'(out_principal_min));
        compare_field("principal_direction", e.direction,
                      longint'({1'b0, out_principal_direction}));
      end
    end
  end

  // Offer one angle and wait until it is taken.
  task automatic send_angle(input logic [15:0] angle);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rotation_angle <= angle;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_stresses(angle));
  endtask

  // Drop valid at the edge of the last acceptance, then wait for every result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stress(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_SII: stress_sii = value;
      REG_SJJ: stress_sjj = value;
      REG_SIJ: stress_sij = value;
      default: ;
    endcase
  endtask

  task automatic set_stress_state(input logic [31:0] sii, input logic [31:0] sjj,
                                  input logic [31:0] sij);
    write_stress(REG_SII, sii);
    write_stress(REG_SJJ, sjj);
    write_stress(REG_SIJ, sij);
  endtask

  function automatic logic [31:0] random_stress();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 2000) : -$urandom_range(0, 2000);
      3: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Special angles on a zero stress state, then on one mixed state.
  task automatic test_directed_angles();
    logic [15:0] angles[11] = '{16'd0, 16'd1, 16'd8192, 16'd16383, 16'd16384,
                                16'd16385, 16'd32768, 16'd49152, 16'd65535,
                                16'h5555, 16'hAAAA};
    foreach (angles[k]) send_angle(angles[k]);
    drain_results();
    // Negative normal stress difference and nonzero shear.
    set_stress_state(32'h0001_0000, 32'h0005_0000, 32'hFFFE_0000);
    foreach (angles[k]) send_angle(angles[k]);
    drain_results();
  endtask

  // Extreme stresses that drive saturation and radius overflow, a degenerate circle and an unused index write.
  task automatic test_extremes();
    set_stress_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    for (int k = 0; k < 4; k++) send_angle(16'(k * 4096 + 1000));
    drain_results();
    set_stress_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_angle(16'd0);
    send_angle(16'd65535);
    drain_results();
    // Equal normal stresses and no shear: the circle shrinks to a point.
    set_stress_state(32'h0003_0000, 32'h0003_0000, 32'h0);
    send_angle(16'd12345);
    drain_results();
    // A write to the unused index must leave the state alone.
    write_stress(2'd3, 32'hDEAD_BEEF);
    send_angle(16'd777);
    drain_results();
  endtask

  // Random angles over several random stress states with random idling.
  task automatic test_random_phases();
    for (int phase = 0; phase < 9; phase++) begin
      set_stress_state(random_stress(), random_stress(), random_stress());
      tx_idle_en = (phase % 3) != 0;
      rx_idle_en = (phase % 3) != 1;
      for (int k = 0; k < 150; k++) send_angle(16'($urandom));
      drain_results();
    end
  endtask

  // Long receiver hold while the sender keeps offering items.
  task automatic test_backpressure();
    set_stress_state($urandom, $urandom, $urandom);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    fork
      begin
        rx_hold = 1'b1;
        repeat (200) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int k = 0; k < 100; k++) send_angle(16'($urandom));
    join
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_angles();
    test_extremes();
    test_random_phases();
    test_backpressure();
    drain_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("plane_stress_transform verification clean");
    end else begin
      $display("plane_stress_transform verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/psx_pkg.sv
hw/rtl/psx_cell.sv
hw/rtl/psx_post.sv
hw/rtl/plane_stress_transform.sv
test/testbench.sv
